// ===== hdl/ots_pkg.sv =====
// shared types, token kinds and keyword tables of the oberon token scanner
package ots_pkg;

  localparam int KW_COUNT = 19;
  localparam int KW_MAX   = 9;

  // token kinds
  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_PLUS    = 5'd1;
  localparam logic [4:0] K_MINUS   = 5'd2;
  localparam logic [4:0] K_AND     = 5'd3;
  localparam logic [4:0] K_TIMES   = 5'd4;
  localparam logic [4:0] K_NUMBER  = 5'd5;
  localparam logic [4:0] K_LPAREN  = 5'd6;
  localparam logic [4:0] K_RPAREN  = 5'd7;
  localparam logic [4:0] K_LBRAK   = 5'd8;
  localparam logic [4:0] K_RBRAK   = 5'd9;
  localparam logic [4:0] K_EQL     = 5'd10;
  localparam logic [4:0] K_LEQ     = 5'd11;
  localparam logic [4:0] K_LSS     = 5'd12;
  localparam logic [4:0] K_GTR     = 5'd13;
  localparam logic [4:0] K_GEQ     = 5'd14;
  localparam logic [4:0] K_NEQ     = 5'd15;
  localparam logic [4:0] K_PERIOD  = 5'd16;
  localparam logic [4:0] K_COMMA   = 5'd17;
  localparam logic [4:0] K_SEMI    = 5'd18;
  localparam logic [4:0] K_NOT     = 5'd19;
  localparam logic [4:0] K_COLON   = 5'd20;
  localparam logic [4:0] K_BECOMES = 5'd21;
  localparam logic [4:0] K_KEYWORD = 5'd22;
  localparam logic [4:0] K_NAME    = 5'd23;
  localparam logic [4:0] K_DIV     = 5'd24;
  localparam logic [4:0] K_MOD     = 5'd25;
  localparam logic [4:0] K_OR      = 5'd26;
  localparam logic [4:0] K_INVALID = 5'd27;

  // keyword spellings, left-justified, first character in the top byte
  localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
    {"DIV", 48'd0}, {"MOD", 48'd0}, {"OR", 56'd0}, {"OF", 56'd0},
    {"THEN", 40'd0}, {"DO", 56'd0}, {"END", 48'd0}, {"ELSE", 40'd0},
    {"ELSIF", 32'd0}, {"IF", 56'd0}, {"WHILE", 32'd0}, {"ARRAY", 32'd0},
    {"RECORD", 24'd0}, {"CONST", 32'd0}, {"TYPE", 40'd0}, {"VAR", 48'd0},
    {"PROCEDURE"}, {"BEGIN", 32'd0}, {"MODULE", 24'd0}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd3, 4'd2, 4'd2, 4'd4, 4'd2, 4'd3, 4'd4, 4'd5, 4'd2,
    4'd5, 4'd5, 4'd6, 4'd5, 4'd4, 4'd3, 4'd9, 4'd5, 4'd6
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [4:0]  keyword_index;
    logic [31:0] number_value;
    logic        number_overflow;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic        last_of_run;
  } tok_t;

  // tokens caused by one source byte
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } tok_pair_t;

endpackage

// ===== hdl/ots_byte_if.sv =====
// source byte channel
interface ots_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// ===== hdl/ots_tok_if.sv =====
// token result channel
interface ots_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [4:0]  keyword_index;
  logic [31:0] number_value;
  logic        number_overflow;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic [23:0] line_number;
  logic        last_of_run;

  modport source (output valid, output kind, output keyword_index, output number_value,
                  output number_overflow, output start_offset, output token_length,
                  output line_number, output last_of_run, input ready);
  modport sink (input valid, input kind, input keyword_index, input number_value,
                input number_overflow, input start_offset, input token_length,
                input line_number, input last_of_run, output ready);
endinterface

// ===== hdl/ots_core.sv =====
// scanner state and per-byte token logic
module ots_core #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int DEPTH_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_ch,
  output ots_pkg::tok_pair_t res
);
  import ots_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef enum logic [9:0] {
    M_IDLE      = 10'b00_0000_0001,
    M_NUM       = 10'b00_0000_0010,
    M_WORD      = 10'b00_0000_0100,
    M_LPAREN    = 10'b00_0000_1000,
    M_LT        = 10'b00_0001_0000,
    M_GT        = 10'b00_0010_0000,
    M_COLON     = 10'b00_0100_0000,
    M_CMT       = 10'b00_1000_0000,
    M_CMT_STAR  = 10'b01_0000_0000,
    M_CMT_PAREN = 10'b10_0000_0000
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] pstart_r, pstart_nxt;
  logic [LINE_BITS-1:0]   pline_r, pline_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [7:0]             word_r [KW_MAX];
  logic [7:0]             word_nxt [KW_MAX];
  logic [15:0]            len_r, len_nxt;
  logic [DEPTH_BITS-1:0]  depth_r, depth_nxt;

  logic        is_dig, is_alp;
  logic [35:0] mul10;
  logic        kw_found;
  logic [4:0]  kw_idx;
  logic [4:0]  word_kind;

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [4:0] kw,
                                  input logic [31:0] val, input logic ovf,
                                  input logic [31:0] start, input logic [15:0] len,
                                  input logic [23:0] line);
    tok_t t;
    t.kind            = kind;
    t.keyword_index   = kw;
    t.number_value    = val;
    t.number_overflow = ovf;
    t.start_offset    = start;
    t.token_length    = len;
    t.line_number     = line;
    t.last_of_run     = 1'b0;
    return t;
  endfunction

  assign is_dig = (in_ch >= "0") && (in_ch <= "9");
  assign is_alp = ((in_ch >= "a") && (in_ch <= "z")) || ((in_ch >= "A") && (in_ch <= "Z"))
                  || (in_ch == "_");
  assign mul10  = 36'({acc_r, 3'b000}) + 36'({acc_r, 1'b0}) + 36'(in_ch[3:0]);

  // keyword lookup over the stored first bytes of the word
  always_comb begin
    logic hit;
    kw_found = 1'b0;
    kw_idx   = 5'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = (len_r == 16'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX; i++) begin
        if (i < int'(KW_LEN[k])) begin
          hit = hit && (word_r[i] == KW_TEXT[k][8*(KW_MAX-i)-1 -: 8]);
        end
      end
      if (hit) begin
        kw_found = 1'b1;
        kw_idx   = 5'(k);
      end
    end
    if (!kw_found) begin
      word_kind = K_NAME;
    end else if (kw_idx == 5'd0) begin
      word_kind = K_DIV;
    end else if (kw_idx == 5'd1) begin
      word_kind = K_MOD;
    end else if (kw_idx == 5'd2) begin
      word_kind = K_OR;
    end else begin
      word_kind = K_KEYWORD;
    end
  end

  always_comb begin
    logic        go_idle;
    logic        eof_hit;
    logic        pend_v;
    tok_t        pend_tok;
    logic        idle_v;
    tok_t        idle_tok;
    logic [4:0]  single;
    logic        single_v;
    logic [31:0] cur_start;
    logic [23:0] cur_line;

    go_idle    = 1'b0;
    eof_hit    = 1'b0;
    pend_v     = 1'b0;
    pend_tok   = '0;
    idle_v     = 1'b0;
    idle_tok   = '0;
    single     = K_INVALID;
    single_v   = 1'b0;
    cur_start  = 32'(pos_r);
    cur_line   = 24'(line_r);
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    pstart_nxt = pstart_r;
    pline_nxt  = pline_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    word_nxt   = word_r;
    len_nxt    = len_r;
    depth_nxt  = depth_r;

    case (mode_r)
      M_NUM: begin
        if (is_dig) begin
          if (!ovf_r) begin
            if (mul10[35:32] != 4'd0) begin
              ovf_nxt = 1'b1;
              acc_nxt = 32'd0;
            end else begin
              acc_nxt = mul10[31:0];
            end
          end
          if (len_r != 16'hFFFF) len_nxt = len_r + 16'd1;
        end else begin
          pend_v   = 1'b1;
          pend_tok = mk_tok(K_NUMBER, 5'd0, acc_r, ovf_r, 32'(pstart_r), len_r,
                            24'(pline_r));
          go_idle  = 1'b1;
        end
      end
      M_WORD: begin
        if (is_alp || is_dig) begin
          if (len_r < 16'(KW_MAX)) word_nxt[len_r[3:0]] = in_ch;
          if (len_r != 16'hFFFF) len_nxt = len_r + 16'd1;
        end else begin
          pend_v   = 1'b1;
          pend_tok = mk_tok(word_kind, kw_idx, 32'd0, 1'b0, 32'(pstart_r), len_r,
                            24'(pline_r));
          go_idle  = 1'b1;
        end
      end
      M_LT, M_GT, M_COLON: begin
        pend_v = 1'b1;
        if (in_ch == "=") begin
          pend_tok = mk_tok((mode_r == M_LT) ? K_LEQ : (mode_r == M_GT) ? K_GEQ : K_BECOMES,
                            5'd0, 32'd0, 1'b0, 32'(pstart_r), 16'd2, 24'(pline_r));
          mode_nxt = M_IDLE;
        end else begin
          pend_tok = mk_tok((mode_r == M_LT) ? K_LSS : (mode_r == M_GT) ? K_GTR : K_COLON,
                            5'd0, 32'd0, 1'b0, 32'(pstart_r), 16'd1, 24'(pline_r));
          go_idle  = 1'b1;
        end
      end
      M_LPAREN: begin
        if (in_ch == "*") begin
          mode_nxt  = M_CMT;
          depth_nxt = DEPTH_BITS'(1);
        end else begin
          pend_v   = 1'b1;
          pend_tok = mk_tok(K_LPAREN, 5'd0, 32'd0, 1'b0, 32'(pstart_r), 16'd1,
                            24'(pline_r));
          go_idle  = 1'b1;
        end
      end
      M_CMT, M_CMT_STAR, M_CMT_PAREN: begin
        if (in_ch == CH_NUL) begin
          eof_hit = 1'b1;
        end else if ((in_ch == ")") && (mode_r == M_CMT_STAR)) begin
          if (depth_r <= DEPTH_BITS'(1)) begin
            depth_nxt = '0;
            mode_nxt  = M_IDLE;
          end else begin
            depth_nxt = depth_r - DEPTH_BITS'(1);
            mode_nxt  = M_CMT;
          end
        end else if ((in_ch == "*") && (mode_r == M_CMT_PAREN)) begin
          if (depth_r != '1) depth_nxt = depth_r + DEPTH_BITS'(1);
          mode_nxt = M_CMT;
        end else if (in_ch == "*") begin
          mode_nxt = M_CMT_STAR;
        end else if (in_ch == "(") begin
          mode_nxt = M_CMT_PAREN;
        end else begin
          if ((in_ch == CH_LF) && (line_r != '1)) line_nxt = line_r + LINE_BITS'(1);
          mode_nxt = M_CMT;
        end
      end
      default: go_idle = 1'b1;
    endcase

    // scan the byte with nothing pending
    if (go_idle) begin
      mode_nxt = M_IDLE;
      case (in_ch)
        CH_NUL: eof_hit = 1'b1;
        " ", CH_TAB, CH_CR: ;
        CH_LF: if (line_r != '1) line_nxt = line_r + LINE_BITS'(1);
        "(", "<", ">", ":": begin
          mode_nxt   = (in_ch == "(") ? M_LPAREN : (in_ch == "<") ? M_LT :
                       (in_ch == ">") ? M_GT : M_COLON;
          pstart_nxt = pos_r;
          pline_nxt  = line_r;
        end
        "+": begin single_v = 1'b1; single = K_PLUS;   end
        "-": begin single_v = 1'b1; single = K_MINUS;  end
        "&": begin single_v = 1'b1; single = K_AND;    end
        "*": begin single_v = 1'b1; single = K_TIMES;  end
        ")": begin single_v = 1'b1; single = K_RPAREN; end
        "[": begin single_v = 1'b1; single = K_LBRAK;  end
        "]": begin single_v = 1'b1; single = K_RBRAK;  end
        "=": begin single_v = 1'b1; single = K_EQL;    end
        "#": begin single_v = 1'b1; single = K_NEQ;    end
        ".": begin single_v = 1'b1; single = K_PERIOD; end
        ",": begin single_v = 1'b1; single = K_COMMA;  end
        ";": begin single_v = 1'b1; single = K_SEMI;   end
        "~": begin single_v = 1'b1; single = K_NOT;    end
        default: begin
          if (is_dig) begin
            mode_nxt   = M_NUM;
            pstart_nxt = pos_r;
            pline_nxt  = line_r;
            acc_nxt    = 32'(in_ch[3:0]);
            ovf_nxt    = 1'b0;
            len_nxt    = 16'd1;
          end else if (is_alp) begin
            mode_nxt    = M_WORD;
            pstart_nxt  = pos_r;
            pline_nxt   = line_r;
            word_nxt[0] = in_ch;
            len_nxt     = 16'd1;
          end else begin
            single_v = 1'b1;
            single   = K_INVALID;
          end
        end
      endcase
      if (single_v) begin
        idle_v   = 1'b1;
        idle_tok = mk_tok(single, 5'd0, 32'd0, 1'b0, cur_start, 16'd1, cur_line);
      end
    end

    // end of text: report, then restart line, offset and comment nesting
    if (eof_hit) begin
      idle_v    = 1'b1;
      idle_tok  = mk_tok(K_EOF, 5'd0, 32'd0, 1'b0, cur_start, 16'd0, cur_line);
      mode_nxt  = M_IDLE;
      depth_nxt = '0;
      line_nxt  = LINE_BITS'(1);
      pos_nxt   = '0;
    end else begin
      pos_nxt   = pos_r + OFFSET_BITS'(1);
    end

    res = '0;
    if (pend_v) begin
      res.tok0 = pend_tok;
      res.tok1 = idle_tok;
      if (idle_v) begin
        res.count            = 2'd2;
        res.tok1.last_of_run = 1'b1;
      end else begin
        res.count            = 2'd1;
        res.tok0.last_of_run = 1'b1;
      end
    end else if (idle_v) begin
      res.count            = 2'd1;
      res.tok0             = idle_tok;
      res.tok0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      line_r   <= LINE_BITS'(1);
      pos_r    <= '0;
      pstart_r <= '0;
      pline_r  <= LINE_BITS'(1);
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      len_r    <= '0;
      depth_r  <= '0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      pline_r  <= pline_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      len_r    <= len_nxt;
      depth_r  <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) word_r <= word_nxt;
  end

  // nesting depth is nonzero exactly while inside a comment
  a_depth_in_cmt: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r != '0) |-> ((mode_r == M_CMT) || (mode_r == M_CMT_STAR) ||
                         (mode_r == M_CMT_PAREN)))
    else $error("comment depth set outside a comment");

  a_cmt_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
    ((mode_r == M_CMT) || (mode_r == M_CMT_STAR) || (mode_r == M_CMT_PAREN))
      |-> (depth_r != '0))
    else $error("inside a comment with zero depth");

  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch == CH_NUL)) |=> ((pos_r == '0) && (line_r == LINE_BITS'(1))))
    else $error("counters not restarted after end of text");

endmodule

// ===== hdl/oberon_token_scanner_top.sv =====
// top level of the oberon token scanner: byte input, token queue, token output
//
// usage
//   in_chan carries one source byte per transaction (ch); byte zero ends the text,
//   gives an EOF token and restarts line and offset counting
//   out_chan carries one token per transaction; a byte gives zero, one or two
//   tokens, and last_of_run marks the final token caused by a byte
//   one byte is taken per cycle while in_chan.ready is high; a token is registered
//   in the queue before it appears on out_chan (queue register, no combinational path
//   from in_chan to out_chan)
//   tokens wait in a four-entry queue; in_chan.ready drops while the queue
//   holds three or more, so a stalled receiver backs up into the byte source
//   without losing a token; a byte that closes a pending token and is a token
//   itself fills two queue entries
//   throughput is set by the queue drain: one token per cycle while out_chan.ready
//   is high, so one byte per cycle as long as bytes average at most one token
//   reset (rst_n low, synchronous) empties the queue and returns the scanner to
//   line 1, offset 0, nothing pending and no open comment
module oberon_token_scanner_top #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int DEPTH_BITS  = 8
) (
  input logic         clk,
  input logic         rst_n,
  ots_byte_if.sink    in_chan,
  ots_tok_if.source   out_chan
);
  import ots_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  tok_pair_t         res;
  logic              in_fire;
  logic              out_fire;
  tok_t              q_r [QDEPTH];
  logic [QAW-1:0]    head_r, head_nxt;
  logic [QAW:0]      cnt_r, cnt_nxt;
  logic [QAW-1:0]    tail;
  tok_t              head_tok;

  // scanner core: state update happens on the accepted byte
  ots_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .DEPTH_BITS  (DEPTH_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_ch   (in_chan.ch),
    .res     (res)
  );

  // room for two tokens is needed before a byte is taken
  assign in_chan.ready = (cnt_r <= (QAW+1)'(QDEPTH - 2));
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_chan.valid && out_chan.ready;
  assign tail          = head_r + cnt_r[QAW-1:0];

  always_comb begin
    head_nxt = out_fire ? head_r + QAW'(1) : head_r;
    cnt_nxt  = cnt_r + (in_fire ? (QAW+1)'(res.count) : '0) - (out_fire ? (QAW+1)'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && (res.count != 2'd0)) q_r[tail] <= res.tok0;
    if (in_fire && (res.count == 2'd2)) q_r[tail + QAW'(1)] <= res.tok1;
  end

  assign head_tok                 = q_r[head_r];
  assign out_chan.valid           = (cnt_r != '0);
  assign out_chan.kind            = head_tok.kind;
  assign out_chan.keyword_index   = head_tok.keyword_index;
  assign out_chan.number_value    = head_tok.number_value;
  assign out_chan.number_overflow = head_tok.number_overflow;
  assign out_chan.start_offset    = head_tok.start_offset;
  assign out_chan.token_length    = head_tok.token_length;
  assign out_chan.line_number     = head_tok.line_number;
  assign out_chan.last_of_run     = head_tok.last_of_run;

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("token queue overfilled");

  a_eof_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.ch == 8'h00)) |=> (cnt_r != '0))
    else $error("end of text gave no token");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind == K_EOF)) |-> out_chan.last_of_run)
    else $error("EOF token not marked last of its byte");

endmodule
